[hw/rtl/bti_pkg.sv]
`default_nettype none

package bti_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_ZERO_WIDTH = 3'd2;
  localparam logic [2:0] ST_EMPTY      = 3'd3;
  localparam logic [2:0] ST_SAT        = 3'd4;

  localparam logic [2:0] RES_NONE  = 3'd0;
  localparam logic [2:0] RES_ITEM  = 3'd1;
  localparam logic [2:0] RES_RDVAL = 3'd2;
  localparam logic [2:0] RES_YLAST = 3'd3;
  localparam logic [2:0] RES_ZW    = 3'd4;
  localparam logic [2:0] RES_ARITH = 3'd5;

  localparam int DIV_STEPS = 33;

  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] position;
    logic signed [31:0] point_value;
    logic               extrapolate;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [4:0]         slot_index;
    logic [2:0]         status;
  } out_t;

  typedef struct packed {
    logic       accept;
    logic       take_last;
    logic       take_first;
    logic       scan;
    logic       setup;
    logic       mul;
    logic       add;
    logic       dinit;
    logic       dstep;
    logic [2:0] res_sel;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       cnt_zero;
    logic       cnt_one;
    logic       below;
    logic       above;
    logic       extrap;
    logic       stop;
    logic       zero_w;
    logic       ovf;
    logic       div_last;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/bti_ctrl.sv]
`default_nettype none

module bti_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bti_pkg::sts_t sts,
  output bti_pkg::cmd_t cmd
);
  import bti_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ONE   = 4'd1;
  localparam logic [3:0] S_LAST  = 4'd2;
  localparam logic [3:0] S_FIRST = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_SETUP = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_ADD   = 4'd7;
  localparam logic [3:0] S_DINIT = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept  = 1'b1;
          cmd.res_sel = RES_ITEM;
          if (sts.op == OP_QUERY && !sts.cnt_zero) begin
            state_next = sts.cnt_one ? S_ONE : S_LAST;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_ONE: begin
        cmd.res_sel = RES_RDVAL;
        state_next  = S_DONE;
      end
      S_LAST: begin
        cmd.take_last = 1'b1;
        state_next    = S_FIRST;
      end
      S_FIRST: begin
        cmd.take_first = 1'b1;
        priority if (!sts.extrap && sts.below) begin
          cmd.res_sel = RES_RDVAL;
          state_next  = S_DONE;
        end else if (!sts.extrap && sts.above) begin
          cmd.res_sel = RES_YLAST;
          state_next  = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.stop) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        if (sts.zero_w) begin
          cmd.res_sel = RES_ZW;
          state_next  = S_DONE;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.dinit  = 1'b1;
        state_next = sts.ovf ? S_FIN : S_DIV;
      end
      S_DIV: begin
        cmd.dstep = 1'b1;
        if (sts.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.res_sel = RES_ARITH;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bti_dp.sv]
`default_nettype none

module bti_dp #(
  parameter int MAX_POINTS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  bti_pkg::in_t  req,
  input  bti_pkg::cmd_t cmd,
  output bti_pkg::sts_t sts,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bti_pkg::out_t rsp
);
  import bti_pkg::*;

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int IW = $clog2(MAX_POINTS);

  logic signed [31:0] pos_mem [MAX_POINTS];
  logic signed [31:0] val_mem [MAX_POINTS];

  logic [CW-1:0]      count;
  logic [CW-1:0]      cnt_m1;
  logic [IW-1:0]      last_idx;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      idx_next;
  logic               full;
  logic               wr_en;

  logic signed [31:0] rd_pos;
  logic signed [31:0] rd_val;
  logic signed [31:0] q;
  logic               extrap;
  logic               above_r;
  logic               below_r;
  logic signed [31:0] ylast;
  logic signed [31:0] x1;
  logic signed [31:0] y1;
  logic signed [31:0] x2;
  logic signed [31:0] y2;

  logic signed [32:0] dy;
  logic signed [32:0] dq;
  logic signed [32:0] dx;
  logic [31:0]        ady;
  logic [31:0]        adq;
  logic [31:0]        adx;
  logic               neg;
  logic [63:0]        prod;
  logic [63:0]        num;

  logic [31:0]        rem;
  logic [32:0]        qs;
  logic [5:0]         dcnt;
  logic               ovf_r;
  logic [32:0]        div_t;
  logic               div_ge;
  logic [31:0]        rem_n;

  logic signed [34:0] sum;
  logic               sat_hi;
  logic               sat_lo;
  out_t               item_res;
  out_t               arith_res;
  out_t               res;

  logic below_c;
  logic stop_c;

  assign cnt_m1   = count - CW'(1);
  assign last_idx = cnt_m1[IW-1:0];
  assign full     = (count == CW'(MAX_POINTS));
  assign wr_en    = cmd.accept && (req.op == OP_APPEND) && !full;

  assign below_c = (rd_pos > q);
  assign stop_c  = below_r || (!above_r && (rd_pos >= q)) || (idx == last_idx);

  always_comb begin
    priority if (cmd.accept) begin
      idx_next = last_idx;
    end else if (cmd.take_last) begin
      idx_next = '0;
    end else if (cmd.take_first) begin
      idx_next = IW'(1);
    end else if (cmd.scan && !stop_c) begin
      idx_next = idx + IW'(1);
    end else begin
      idx_next = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_mem[count[IW-1:0]] <= req.position;
      val_mem[count[IW-1:0]] <= req.point_value;
    end
    rd_pos <= pos_mem[idx_next];
    rd_val <= val_mem[idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept && req.op == OP_CLEAR) begin
      count <= '0;
    end else if (wr_en) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (cmd.accept) begin
      q      <= req.position;
      extrap <= req.extrapolate;
    end
    if (cmd.take_last) begin
      above_r <= (rd_pos < q);
      ylast   <= rd_val;
    end
    if (cmd.take_first) begin
      below_r <= below_c;
      x1      <= rd_pos;
      y1      <= rd_val;
    end
    if (cmd.scan) begin
      if (stop_c) begin
        x2 <= rd_pos;
        y2 <= rd_val;
      end else begin
        x1 <= rd_pos;
        y1 <= rd_val;
      end
    end
  end

  assign dy = 33'(y2) - 33'(y1);
  assign dq = 33'(q) - 33'(x1);
  assign dx = 33'(x2) - 33'(x1);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      ady <= dy[32] ? 32'(-dy) : dy[31:0];
      adq <= dq[32] ? 32'(-dq) : dq[31:0];
      adx <= dx[32] ? 32'(-dx) : dx[31:0];
      neg <= dy[32] ^ dq[32] ^ dx[32];
    end
    if (cmd.mul) begin
      prod <= ady * adq;
    end
    if (cmd.add) begin
      num <= prod + 64'(adx[31:1]);
    end
  end

  assign div_t  = {rem, qs[32]};
  assign div_ge = (div_t >= {1'b0, adx});
  assign rem_n  = div_ge ? 32'(div_t - {1'b0, adx}) : div_t[31:0];

  always_ff @(posedge clk) begin
    if (cmd.dinit) begin
      ovf_r <= ({1'b0, num[63:33]} >= adx);
      rem   <= {1'b0, num[63:33]};
      qs    <= num[32:0];
      dcnt  <= '0;
    end else if (cmd.dstep) begin
      rem  <= rem_n;
      qs   <= {qs[31:0], div_ge};
      dcnt <= dcnt + 6'd1;
    end
  end

  always_comb begin
    sum    = neg ? (35'(y1) - $signed({2'b00, qs})) : (35'(y1) + $signed({2'b00, qs}));
    sat_hi = !sum[34] && (sum[33:31] != 3'b000);
    sat_lo = sum[34] && (sum[33:31] != 3'b111);
    arith_res            = '0;
    arith_res.status     = ST_OK;
    arith_res.result_value = sum[31:0];
    priority if (ovf_r) begin
      arith_res.result_value = neg ? VAL_MIN : VAL_MAX;
      arith_res.status       = ST_SAT;
    end else if (sat_hi) begin
      arith_res.result_value = VAL_MAX;
      arith_res.status       = ST_SAT;
    end else if (sat_lo) begin
      arith_res.result_value = VAL_MIN;
      arith_res.status       = ST_SAT;
    end else begin
      arith_res.status = ST_OK;
    end
  end

  always_comb begin
    item_res = '0;
    unique case (req.op)
      OP_APPEND: begin
        if (full) begin
          item_res.status = ST_FULL;
        end else begin
          item_res.slot_index = 5'(count);
        end
      end
      OP_QUERY: begin
        item_res.status = (count == '0) ? ST_EMPTY : ST_OK;
      end
      default: begin
        item_res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (cmd.res_sel)
      RES_ITEM:  res <= item_res;
      RES_RDVAL: res <= '{result_value: rd_val, slot_index: 5'd0, status: ST_OK};
      RES_YLAST: res <= '{result_value: ylast, slot_index: 5'd0, status: ST_OK};
      RES_ZW:    res <= '{result_value: y1, slot_index: 5'd0, status: ST_ZERO_WIDTH};
      RES_ARITH: res <= arith_res;
      default:   res <= res;
    endcase
  end

  assign sts.op       = req.op;
  assign sts.cnt_zero = (count == '0);
  assign sts.cnt_one  = (count == CW'(1));
  assign sts.below    = below_c;
  assign sts.above    = above_r;
  assign sts.extrap   = extrap;
  assign sts.stop     = stop_c;
  assign sts.zero_w   = (x2 == x1);
  assign sts.ovf      = ({1'b0, num[63:33]} >= adx);
  assign sts.div_last = (dcnt == 6'(DIV_STEPS - 1));
  assign sts.out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/breakpoint_table_interpolator_top.sv]
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_ready  | bti_pkg::in_t
// rsp     | out       | rsp_valid/rsp_ready  | bti_pkg::out_t
//
// Clear, append, an unused op and an empty-table query go from acceptance straight to loading the
// output register; a single-point query first reads its one entry and a clamped query the last and first.
// An interpolating query scans k breakpoints (1 to MAX_POINTS-1) through the single read port of the
// tables and then runs 33 steps of the one-bit-per-cycle divider; a zero-width segment ends after the
// scan, and a quotient too large for the result skips the divider.
// Reset empties the table and drops any result not yet transferred.
// A stalled output holds the next item in its final state until the output register frees.
`default_nettype none

module breakpoint_table_interpolator_top #(
  parameter int MAX_POINTS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bti_pkg::in_t  req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bti_pkg::out_t rsp
);
  import bti_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bti_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bti_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

[hw/rtl/bti_check.sv]
`default_nettype none

module bti_check (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input bti_pkg::in_t  req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input bti_pkg::out_t rsp
);
  import bti_pkg::*;

  logic [1:0] pending;
  logic       req_xfer;
  logic       rsp_xfer;

  assign req_xfer = req_valid && req_ready;
  assign rsp_xfer = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, req_xfer} - {1'b0, rsp_xfer};
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed or dropped");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("result without an accepted item");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("too many items in flight");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_EMPTY)
      |-> rsp.result_value == 32'sd0 && rsp.slot_index == 5'd0)
    else $error("full or empty result carries nonzero fields");

endmodule

bind breakpoint_table_interpolator_top bti_check u_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire

[verif/bti_checker.sv]
module bti_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  bti_pkg::in_t  req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  bti_pkg::out_t rsp,
  output int unsigned   fail_count,
  output int unsigned   pending,
  output int unsigned   checked,
  output int unsigned   sat_hits,
  output int unsigned   zero_width_hits,
  output int unsigned   empty_hits,
  output int unsigned   full_hits
);
  timeunit 1ns;
  timeprecision 1ps;
  import bti_pkg::*;

  localparam int TABLE_DEPTH = 32;

  logic signed [31:0] pos_tab [TABLE_DEPTH];
  logic signed [31:0] val_tab [TABLE_DEPTH];
  int                 held;
  out_t               awaited_answers [$];

  task automatic report_mismatch(input string line);
    $display("mismatch: %s", line);
    fail_count++;
  endtask

  // The quotient magnitude is rounded to nearest with ties away from zero and the sign is
  // applied afterwards, so the sum is formed in 64 bits before it is clipped.
  function automatic logic signed [31:0] blend_segment(input longint y1, input longint dy,
                                                       input longint dq, input longint dx,
                                                       output logic clipped);
    logic        neg;
    logic [63:0] ady, adq, adx, mag, quo;
    longint      sum;
    neg = (dy < 0) ^ (dq < 0) ^ (dx < 0);
    ady = (dy < 0) ? -dy : dy;
    adq = (dq < 0) ? -dq : dq;
    adx = (dx < 0) ? -dx : dx;
    mag = ady * adq;
    quo = (mag + adx / 2) / adx;
    if (quo > (64'd1 << 40)) quo = 64'd1 << 40;
    sum = neg ? y1 - longint'(quo) : y1 + longint'(quo);
    clipped = 1'b0;
    if (sum > longint'(VAL_MAX)) begin
      sum = longint'(VAL_MAX);
      clipped = 1'b1;
    end
    if (sum < longint'(VAL_MIN)) begin
      sum = longint'(VAL_MIN);
      clipped = 1'b1;
    end
    return sum[31:0];
  endfunction

  function automatic out_t predict_answer(input in_t item);
    out_t   ans;
    longint q, x1, x2, y1, y2;
    int     seg;
    logic   below, above, found, clipped;
    ans = '0;
    q = longint'(item.position);
    case (item.op)
      OP_CLEAR: held = 0;
      OP_APPEND: begin
        if (held >= TABLE_DEPTH) begin
          ans.status = ST_FULL;
        end else begin
          pos_tab[held] = item.position;
          val_tab[held] = item.point_value;
          ans.slot_index = 5'(held);
          held++;
        end
      end
      OP_QUERY: begin
        if (held == 0) begin
          ans.status = ST_EMPTY;
        end else if (held == 1) begin
          ans.result_value = val_tab[0];
        end else begin
          seg = held - 1;
          found = 1'b0;
          below = longint'(pos_tab[0]) > q;
          above = longint'(pos_tab[held-1]) < q;
          if (below) begin
            seg = 1;
          end else if (!above) begin
            for (int i = 1; i < held; i++) begin
              if (!found && longint'(pos_tab[i]) >= q) begin
                seg = i;
                found = 1'b1;
              end
            end
          end
          if (!item.extrapolate && below) begin
            ans.result_value = val_tab[0];
          end else if (!item.extrapolate && above) begin
            ans.result_value = val_tab[held-1];
          end else begin
            x1 = longint'(pos_tab[seg-1]);
            x2 = longint'(pos_tab[seg]);
            y1 = longint'(val_tab[seg-1]);
            y2 = longint'(val_tab[seg]);
            if (x2 == x1) begin
              ans.result_value = y1[31:0];
              ans.status = ST_ZERO_WIDTH;
            end else begin
              ans.result_value = blend_segment(y1, y2 - y1, q - x1, x2 - x1, clipped);
              if (clipped) ans.status = ST_SAT;
            end
          end
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      awaited_answers.delete();
      held = 0;
      pending <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch($sformatf("result %h arrived with no item waiting", rsp));
        end else begin
          want = awaited_answers.pop_front();
          checked++;
          if (rsp.result_value !== want.result_value)
            report_mismatch($sformatf("result %0d: result_value %h, expected %h",
                                      checked, rsp.result_value, want.result_value));
          if (rsp.slot_index !== want.slot_index)
            report_mismatch($sformatf("result %0d: slot_index %0d, expected %0d",
                                      checked, rsp.slot_index, want.slot_index));
          if (rsp.status !== want.status)
            report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                      checked, rsp.status, want.status));
          case (want.status)
            ST_SAT:        sat_hits++;
            ST_ZERO_WIDTH: zero_width_hits++;
            ST_EMPTY:      empty_hits++;
            ST_FULL:       full_hits++;
            default: ;
          endcase
        end
      end
      if (req_valid && req_ready) awaited_answers.push_back(predict_answer(req));
      pending <= awaited_answers.size();
    end
  end

endmodule

[verif/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bti_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam longint ONE = 64'sh1_0000;
  localparam int ITEM_TARGET = 2000;
  localparam int IDLE_PERCENT = 33;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_OFF_AFTER = 500;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int QUIET_FROM = 700;
  localparam int QUIET_TO = 1000;
  localparam int PAUSE_AT = 1300;
  localparam int TAIL_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  in_t  req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  out_t rsp;

  int unsigned fail_count, pending, checked;
  int unsigned sat_hits, zero_width_hits, empty_hits, full_hits;
  int unsigned sent = 0, n_append = 0, n_query = 0, n_clear = 0, n_unused = 0;
  int unsigned stall_cycles = 0;
  int unsigned taken = 0;
  bit          held_off = 1'b0;
  bit          steady = 1'b0;
  longint      chart [$];

  always #1 clk = ~clk;

  breakpoint_table_interpolator_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  bti_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .req             (req),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .rsp             (rsp),
    .fail_count      (fail_count),
    .pending         (pending),
    .checked         (checked),
    .sat_hits        (sat_hits),
    .zero_width_hits (zero_width_hits),
    .empty_hits      (empty_hits),
    .full_hits       (full_hits)
  );

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: %0d cycles without a transfer", stall_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // The receiver holds off once for a long stretch so that the block backs up into its input.
  initial begin
    forever begin
      @(posedge clk);
      if (rsp_valid && rsp_ready) taken++;
      if (!held_off && taken >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        rsp_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  function automatic in_t make_item(input logic [1:0] op, input longint pos, input longint val,
                                    input int ext);
    in_t item;
    item.op = op;
    item.position = pos[31:0];
    item.point_value = val[31:0];
    item.extrapolate = (ext != 0);
    return item;
  endfunction

  task automatic send_item(input in_t item);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sent++;
    case (item.op)
      OP_CLEAR: begin
        chart.delete();
        n_clear++;
      end
      OP_APPEND: begin
        if (chart.size() < 32) chart.push_back(longint'(item.position));
        n_append++;
      end
      OP_QUERY: n_query++;
      default: n_unused++;
    endcase
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic longint pick_query();
    longint lo, hi;
    int     k, r;
    r = $urandom_range(99);
    if (chart.size() < 2 || r >= 85) return longint'($signed($urandom));
    k = $urandom_range(chart.size() - 1, 1);
    lo = chart[k-1];
    hi = chart[k];
    if (r < 40) return lo + (hi - lo) * longint'($urandom_range(1024)) / 1024;
    if (r < 55) return chart[k];
    if (r < 70) return chart[0] - longint'($urandom_range(32'h40000));
    return chart[chart.size()-1] + longint'($urandom_range(32'h40000));
  endfunction

  task automatic build_table(input int n);
    longint cursor, step_max, val;
    bit     wide;
    wide = ($urandom_range(3) == 0);
    cursor = wide ? -64'sd2147483648 + longint'($urandom_range(32'hffff))
                  : longint'($urandom_range(32'h200000)) - 64'sd1048576;
    step_max = wide ? 64'sd4294967295 / (n + 1) : 64'sd196608;
    for (int i = 0; i < n; i++) begin
      val = wide ? longint'($urandom) : longint'($urandom_range(32'h80000)) - 64'sd262144;
      send_item(make_item(OP_APPEND, cursor, val, $urandom_range(1)));
      if ($urandom_range(19) != 0) cursor += 1 + longint'($urandom) % step_max;
      if (cursor > 64'sd2147483647) cursor = 64'sd2147483647;
    end
  endtask

  initial begin
    int  r, s, n;
    bit  first_seq, paused;
    first_seq = 1'b1;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_item(make_item(OP_QUERY, 0, 0, 0));
    send_item(make_item(OP_UNUSED, -1, -1, 1));
    send_item(make_item(OP_APPEND, ONE, VAL_MAX, 0));
    send_item(make_item(OP_QUERY, 0, 0, 1));
    send_item(make_item(OP_APPEND, 2 * ONE, VAL_MIN, 0));
    send_item(make_item(OP_QUERY, 3 * ONE / 2, 0, 0));
    send_item(make_item(OP_QUERY, VAL_MIN, 0, 1));
    send_item(make_item(OP_QUERY, VAL_MAX, 0, 1));
    send_item(make_item(OP_QUERY, VAL_MIN, 0, 0));
    send_item(make_item(OP_QUERY, VAL_MAX, 0, 0));
    send_item(make_item(OP_QUERY, 2 * ONE, 0, 0));
    send_item(make_item(OP_APPEND, 2 * ONE, 5, 0));
    send_item(make_item(OP_QUERY, 3 * ONE, 0, 1));
    send_item(make_item(OP_CLEAR, -1, -1, 1));
    send_item(make_item(OP_QUERY, ONE, 0, 1));
    send_item(make_item(OP_APPEND, ONE, -3 * ONE, 0));
    send_item(make_item(OP_APPEND, 4 * ONE, 2 * ONE, 0));
    send_item(make_item(OP_APPEND, 2 * ONE, VAL_MAX, 0));
    send_item(make_item(OP_APPEND, 5 * ONE, 9, 0));
    send_item(make_item(OP_QUERY, 9 * ONE / 2, 0, 0));
    send_item(make_item(OP_QUERY, 3 * ONE, 0, 1));
    send_item(make_item(OP_QUERY, 0, 0, 1));
    drain();

    while (sent < ITEM_TARGET) begin
      steady = (sent >= QUIET_FROM && sent < QUIET_TO);
      if (!paused && sent >= PAUSE_AT) begin
        paused = 1'b1;
        drain();
      end
      r = $urandom_range(99);
      if (first_seq || r < 70) begin
        send_item(make_item(OP_CLEAR, $urandom, $urandom, $urandom_range(1)));
        s = $urandom_range(99);
        if (first_seq) n = 34;
        else if (s < 5) n = $urandom_range(1);
        else if (s < 85) n = $urandom_range(8, 2);
        else n = $urandom_range(36, 28);
        first_seq = 1'b0;
        build_table(n);
        repeat ($urandom_range(12, 3))
          send_item(make_item(OP_QUERY, pick_query(), $urandom, $urandom_range(1)));
      end else if (r < 85) begin
        repeat ($urandom_range(4, 1))
          send_item(make_item(OP_APPEND, pick_query(), $urandom, $urandom_range(1)));
        repeat ($urandom_range(6, 1))
          send_item(make_item(OP_QUERY, pick_query(), $urandom, $urandom_range(1)));
      end else begin
        send_item(make_item(2'($urandom_range(3)), $urandom, $urandom, $urandom_range(1)));
      end
    end
    steady = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d items: %0d appends, %0d queries, %0d clears, %0d unused op code.",
             sent, n_append, n_query, n_clear, n_unused);
    $display("Checked %0d results: %0d saturated, %0d zero-width, %0d empty, %0d full.",
             checked, sat_hits, zero_width_hits, empty_hits, full_hits);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
